/* rtl/lpm_pkg.sv */
// Shared types, codes and defaults for the longest prefix match routing table.
package lpm_pkg;

   // Default table depth in routes
   localparam int unsigned ENTRIES_DEFAULT = 32;

   // Request action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOROUTE = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   // Request transfer payload
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] address;
      logic [31:0] route_mask;
      logic [31:0] gateway;
      logic [2:0]  port_in;
   } req_payload_type;

   // Response transfer payload
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_hop;
      logic [2:0]  port_out;
   } rsp_payload_type;

   // One stored route, one RAM word
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [2:0]  port;
   } route_type;

   // Controls from the sequencer to the compare unit
   typedef struct packed {
      logic clear;   // start of a new lookup
      logic sample;  // RAM read data holds a valid route
   } scan_ctrl_type;

endpackage

/* rtl/lpm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lpm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lpm_scan.sv */
// Compare and select unit: keeps the longest matching route seen during a lookup.
module lpm_scan
   import lpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scan_ctrl_type ctrl,
   input  logic [31:0]   lookup_address,
   input  route_type     entry,
   output logic          found,
   output logic [31:0]   best_gateway,
   output logic [2:0]    best_port
);

   logic        found_ff;
   logic        found_in;
   logic [31:0] best_mask_ff;
   logic [31:0] best_mask_in;
   logic [31:0] gateway_ff;
   logic [31:0] gateway_in;
   logic [2:0]  port_ff;
   logic [2:0]  port_in;
   logic        hit;
   logic        take;

   // Route matches when all masked bits agree; strictly longer mask wins
   assign hit  = ((lookup_address ^ entry.dest) & entry.mask) == 32'd0;
   assign take = ctrl.sample && hit && (!found_ff || (entry.mask > best_mask_ff));

   always_comb begin
      found_in     = found_ff;
      best_mask_in = best_mask_ff;
      gateway_in   = gateway_ff;
      port_in      = port_ff;
      if (ctrl.clear) begin
         found_in   = 1'b0;
         gateway_in = 32'd0;
         port_in    = 3'd0;
      end else if (take) begin
         found_in     = 1'b1;
         best_mask_in = entry.mask;
         gateway_in   = entry.gateway;
         port_in      = entry.port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_mask_ff <= best_mask_in;
      gateway_ff   <= gateway_in;
      port_ff      <= port_in;
   end

   assign found        = found_ff;
   assign best_gateway = gateway_ff;
   assign best_port    = port_ff;

endmodule

/* rtl/longest_prefix_match_table.sv */
// Top level of the longest prefix match routing table: sequencer, route RAM, compare unit.
//
// IPv4 routing table of up to ENTRIES routes held in one RAM, one route per word
// (destination, mask, gateway, port). One request is worked on at a time. Insert,
// clear and unused actions go from the idle state straight to the done state. A
// lookup reads the stored routes in insertion order through the single RAM read
// port, one route per cycle, and on an empty table goes straight to the done
// state with no route found. A finished response sits in an output register, so
// the next request is accepted while that response waits to be taken. The first
// of several routes with the same longest mask wins. Unwritten RAM words are
// never read, so no clearing pass is needed after reset.
module longest_prefix_match_table
   import lpm_pkg::*;
#(
   parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type       state_ff;
   state_type       state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] issue_ff;
   logic [CNT_W-1:0] issue_in;
   logic            data_valid_ff;
   logic            data_valid_in;
   logic            last_ff;
   logic            last_in;
   logic            lookup_ff;
   logic            lookup_in;
   logic [31:0]     address_ff;
   logic [31:0]     address_in;
   rsp_payload_type result_ff;
   rsp_payload_type result_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   logic            req_fire;
   logic            wr_en;
   logic [IDX_W-1:0] wr_addr;
   route_type       wr_data;
   logic            rd_en;
   logic [IDX_W-1:0] rd_addr;
   route_type       rd_data;
   scan_ctrl_type   scan_ctrl;
   logic            scan_found;
   logic [31:0]     scan_gateway;
   logic [2:0]      scan_port;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Route storage
   lpm_ram #(
      .WIDTH ($bits(route_type)),
      .DEPTH (ENTRIES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Longest mask selection
   lpm_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (scan_ctrl),
      .lookup_address (address_ff),
      .entry          (rd_data),
      .found          (scan_found),
      .best_gateway   (scan_gateway),
      .best_port      (scan_port)
   );

   // Insert writes the next free word
   assign wr_addr         = count_ff[IDX_W-1:0];
   assign wr_data.dest    = req_payload.address;
   assign wr_data.mask    = req_payload.route_mask;
   assign wr_data.gateway = req_payload.gateway;
   assign wr_data.port    = req_payload.port_in;

   // Sequencer next state
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      issue_in        = issue_ff;
      data_valid_in   = 1'b0;
      last_in         = last_ff;
      lookup_in       = lookup_ff;
      address_in      = address_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = '0;
      scan_ctrl.clear  = 1'b0;
      scan_ctrl.sample = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               lookup_in = 1'b0;
               result_in = '{status: STAT_OK, next_hop: 32'd0, port_out: 3'd0};
               state_in  = S_DONE;
               unique case (req_payload.action)
                  ACT_INSERT: begin
                     if (count_ff < CNT_W'(ENTRIES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        result_in.status = STAT_FULL;
                     end
                  end
                  ACT_LOOKUP: begin
                     address_in = req_payload.address;
                     if (count_ff == '0) begin
                        result_in.status = STAT_NOROUTE;
                     end else begin
                        lookup_in       = 1'b1;
                        scan_ctrl.clear = 1'b1;
                        rd_en           = 1'b1;
                        rd_addr         = '0;
                        issue_in        = CNT_W'(1);
                        data_valid_in   = 1'b1;
                        last_in         = (count_ff == CNT_W'(1));
                        state_in        = S_SCAN;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            scan_ctrl.sample = data_valid_ff;
            // Issue the next route read while earlier data is compared
            if (issue_ff < count_ff) begin
               rd_en         = 1'b1;
               rd_addr       = issue_ff[IDX_W-1:0];
               issue_in      = issue_ff + CNT_W'(1);
               data_valid_in = 1'b1;
               last_in       = ((issue_ff + CNT_W'(1)) == count_ff);
            end
            if (data_valid_ff && last_ff) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (lookup_ff) begin
                  rsp_in.status   = scan_found ? STAT_OK : STAT_NOROUTE;
                  rsp_in.next_hop = scan_gateway;
                  rsp_in.port_out = scan_port;
               end else begin
                  rsp_in = result_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         issue_ff      <= '0;
         data_valid_ff <= 1'b0;
         last_ff       <= 1'b0;
         lookup_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         data_valid_ff <= data_valid_in;
         last_ff       <= last_in;
         lookup_ff     <= lookup_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      address_ff <= address_in;
      result_ff  <= result_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* tb/tb_longest_prefix_match_table.sv */
// Self-checking testbench for the longest prefix match routing table.
module tb_longest_prefix_match_table;
   timeunit 1ns;
   timeprecision 1ps;
   import lpm_pkg::*;

   localparam int unsigned TABLE_DEPTH  = ENTRIES_DEFAULT;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;
   localparam int          RANDOM_ITEMS = 400;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = TABLE_DEPTH + 8;

   // Routing table shadow: predicts one response per accepted request
   class route_table_model;
      logic [31:0]     dest_of    [TABLE_DEPTH];
      logic [31:0]     mask_of    [TABLE_DEPTH];
      logic [31:0]     gateway_of [TABLE_DEPTH];
      logic [2:0]      port_of    [TABLE_DEPTH];
      int unsigned     route_count;
      int unsigned     failures;
      rsp_payload_type route_replies[$];

      function new();
         route_count = 0;
         failures    = 0;
      endfunction

      // Apply one request to the shadow table and queue the reply it causes
      function void note_request(req_payload_type req);
         rsp_payload_type reply;
         logic [31:0]     best_mask;
         bit              hit;
         reply        = '0;
         reply.status = STAT_OK;
         best_mask    = '0;
         hit          = 1'b0;
         case (req.action)
            ACT_INSERT: begin
               if (route_count >= TABLE_DEPTH) begin
                  reply.status = STAT_FULL;
               end else begin
                  dest_of[route_count]    = req.address;
                  mask_of[route_count]    = req.route_mask;
                  gateway_of[route_count] = req.gateway;
                  port_of[route_count]    = req.port_in;
                  route_count++;
               end
            end
            ACT_LOOKUP: begin
               // strictly longer mask replaces, so the earliest route wins a tie
               for (int i = 0; i < route_count; i++) begin
                  if (((req.address ^ dest_of[i]) & mask_of[i]) == '0 &&
                      (!hit || mask_of[i] > best_mask)) begin
                     hit            = 1'b1;
                     best_mask      = mask_of[i];
                     reply.next_hop = gateway_of[i];
                     reply.port_out = port_of[i];
                  end
               end
               if (!hit) reply.status = STAT_NOROUTE;
            end
            ACT_CLEAR: route_count = 0;
            default: ;
         endcase
         route_replies.push_back(reply);
      endfunction

      // Compare one response transfer with the oldest queued reply
      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (route_replies.size() == 0) begin
            $error("unexpected response: status %0d next_hop %h port_out %0d",
                   got.status, got.next_hop, got.port_out);
            failures++;
            return;
         end
         want = route_replies.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.next_hop !== want.next_hop) begin
            $error("next_hop: expected %h, actual %h", want.next_hop, got.next_hop);
            failures++;
         end
         if (got.port_out !== want.port_out) begin
            $error("port_out: expected %0d, actual %0d", want.port_out, got.port_out);
            failures++;
         end
      endfunction

      function int pending();
         return route_replies.size();
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   bit               no_idle     = 1'b0;
   int               stall_count = 0;
   route_table_model routes;

   longest_prefix_match_table #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Response side: drops ready with a chance of about 7 in 100 outside the quiet stretch
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 7);
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) routes.check_response(rsp_payload);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count + 1 >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic req_payload_type make_req(logic [1:0] action, logic [31:0] address,
                                                logic [31:0] route_mask, logic [31:0] gateway,
                                                logic [2:0] port_in);
      req_payload_type r;
      r.action     = action;
      r.address    = address;
      r.route_mask = route_mask;
      r.gateway    = gateway;
      r.port_in    = port_in;
      return r;
   endfunction

   // Mostly contiguous prefixes of any length, sometimes an arbitrary bit pattern
   function automatic logic [31:0] random_mask();
      int unsigned len;
      if ($urandom_range(0, 9) == 0) return $urandom;
      len = $urandom_range(0, 32);
      return (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
   endfunction

   // Drive one request transfer; entered and left at a falling edge
   task automatic send_request(input req_payload_type item);
      while (!no_idle && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      routes.note_request(item);
      @(negedge clock);
   endtask

   task automatic send_random_insert();
      logic [31:0] mask;
      logic [31:0] dest;
      int unsigned idx;
      mask = random_mask();
      dest = $urandom;
      // overlap with a stored route to make competing matches likely
      if (routes.route_count > 0 && $urandom_range(0, 1) == 1) begin
         idx  = $urandom_range(0, routes.route_count - 1);
         dest = routes.dest_of[idx] ^ ($urandom & ~mask & ~routes.mask_of[idx]);
      end
      send_request(make_req(ACT_INSERT, dest, mask, $urandom, 3'($urandom_range(0, 7))));
   endtask

   task automatic send_random_lookup();
      logic [31:0] address;
      int unsigned idx;
      int unsigned pick;
      pick    = $urandom_range(0, 99);
      address = $urandom;
      if (pick < 5) begin
         address = '0;
      end else if (pick < 10) begin
         address = '1;
      end else if (routes.route_count > 0 && pick < 85) begin
         // aim at a stored route, varying only the bits its mask ignores
         idx     = $urandom_range(0, routes.route_count - 1);
         address = routes.dest_of[idx] ^ ($urandom & ~routes.mask_of[idx]);
      end
      send_request(make_req(ACT_LOOKUP, address, $urandom, $urandom,
                            3'($urandom_range(0, 7))));
   endtask

   initial begin
      int random_sent;
      int fill_target;
      int inserted;
      int pick;
      routes = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, unused action, default route, host route, tie,
      // non-contiguous mask, clear, field extremes
      send_request(make_req(ACT_LOOKUP, 32'h0000_0000, '1, '1, 3'd7));
      send_request(make_req(ACT_UNUSED, '1, '1, '1, 3'd7));
      send_request(make_req(ACT_INSERT, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 3'd1));
      send_request(make_req(ACT_LOOKUP, 32'hC0A8_0155, '0, '0, 3'd0));
      send_request(make_req(ACT_LOOKUP, 32'h0A00_0001, '0, '0, 3'd0));
      send_request(make_req(ACT_INSERT, '1, 32'h0000_0000, '1, 3'd7));
      send_request(make_req(ACT_LOOKUP, 32'h0A00_0001, '0, '0, 3'd0));
      send_request(make_req(ACT_INSERT, 32'hC0A8_0155, '1, '0, 3'd0));
      send_request(make_req(ACT_LOOKUP, 32'hC0A8_0155, '0, '0, 3'd0));
      send_request(make_req(ACT_LOOKUP, 32'hC0A8_0156, '0, '0, 3'd0));
      send_request(make_req(ACT_INSERT, 32'hC0A8_01FF, 32'hFFFF_FF00, 32'h1234_5678, 3'd3));
      send_request(make_req(ACT_LOOKUP, 32'hC0A8_0177, '0, '0, 3'd0));
      send_request(make_req(ACT_INSERT, 32'h8000_0001, 32'h8000_0001, 32'hDEAD_BEEF, 3'd5));
      send_request(make_req(ACT_LOOKUP, '1, '1, '1, 3'd7));
      send_request(make_req(ACT_LOOKUP, 32'h0000_0000, '0, '0, 3'd0));
      send_request(make_req(ACT_CLEAR, '1, '1, '1, 3'd7));
      send_request(make_req(ACT_LOOKUP, 32'hC0A8_0155, '0, '0, 3'd0));
      send_request(make_req(ACT_INSERT, '0, '1, '1, 3'd7));
      send_request(make_req(ACT_LOOKUP, '0, '0, '0, 3'd0));
      send_request(make_req(ACT_LOOKUP, 32'h0000_0001, '0, '0, 3'd0));
      send_request(make_req(ACT_CLEAR, '0, '0, '0, 3'd0));

      // Random phases: fill the table to a target with lookups mixed in, then clear.
      // A phase whose target exceeds the table inserts first and never clears midway,
      // so the first phase always overruns the table to reach the full case.
      random_sent = 0;
      fill_target = TABLE_DEPTH + 3;
      while (random_sent < RANDOM_ITEMS) begin
         inserted = 0;
         for (int k = 0; k < 3 * fill_target && random_sent < RANDOM_ITEMS; k++) begin
            no_idle <= (random_sent >= 150 && random_sent < 250);
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               send_request(make_req(ACT_UNUSED, $urandom, $urandom, $urandom,
                                     3'($urandom_range(0, 7))));
            end else begin
               if (pick < 4 && fill_target <= TABLE_DEPTH) begin
                  send_request(make_req(ACT_CLEAR, $urandom, $urandom, $urandom,
                                        3'($urandom_range(0, 7))));
               end else if ((pick < 45 || fill_target > TABLE_DEPTH) &&
                            inserted < fill_target) begin
                  send_random_insert();
                  inserted++;
               end else begin
                  send_random_lookup();
               end
               random_sent++;
            end
         end
         send_request(make_req(ACT_CLEAR, $urandom, $urandom, $urandom,
                               3'($urandom_range(0, 7))));
         random_sent++;
         fill_target = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH + 3 : $urandom_range(1, 12);
      end
      req_valid <= 1'b0;

      // Drain, then allow a lookup's worth of cycles for anything stray
      while (routes.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (routes.failures == 0 && routes.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/lpm_pkg.sv
rtl/lpm_ram.sv
rtl/lpm_scan.sv
rtl/longest_prefix_match_table.sv
tb/tb_longest_prefix_match_table.sv
